[src/bmsfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsfr_pkg
// Shared types and constants for the monitor frame receiver and cell stats.
// ----------------------------------------------------------------------------
package bmsfr_pkg;

  // Frame geometry
  localparam int unsigned FRAME_LEN = 72;
  localparam int unsigned MAX_CELLS = 24;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned CELL_W    = 5;
  localparam int unsigned SUM_W     = 21;

  // Header bytes
  localparam logic [7:0] HDR_BYTE0 = 8'hEB;
  localparam logic [7:0] HDR_BYTE1 = 8'h90;
  localparam logic [7:0] HDR_BYTE3 = 8'hFF;

  // Payload byte positions
  localparam logic [CNT_W-1:0] POS_AVG_LO   = 8'd3;
  localparam logic [CNT_W-1:0] POS_ERR      = 8'd8;
  localparam logic [CNT_W-1:0] POS_BAL_LO   = 8'd12;
  localparam logic [CNT_W-1:0] POS_BAL_ACT  = 8'd17;
  localparam logic [CNT_W-1:0] POS_CELLS    = 8'd18;
  localparam logic [CNT_W-1:0] POS_CELL0_LO = 8'd20;
  localparam logic [CNT_W-1:0] POS_TEMP_LO  = 8'd68;
  localparam logic [CNT_W-1:0] LAST_POS     = CNT_W'(FRAME_LEN - 1);

  // Configuration
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SLAVE_ADDR = 2'd1;
  localparam logic [15:0] TIMEOUT_RST = 16'd500;

  typedef enum logic [1:0] {
    FUNC_BYTE = 2'd0,
    FUNC_TICK = 2'd1,
    FUNC_ARM  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHKSUM   = 2'd1,
    ST_TIMEOUT  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [15:0]       avg_cell_mv;
    logic [7:0]        error_bits;
    logic [15:0]       balance_current;
    logic [7:0]        balance_active;
    logic [CELL_W-1:0] cell_count;
    logic [SUM_W-1:0]  cell_sum_mv;
    logic [15:0]       min_cell_mv;
    logic [CELL_W-1:0] min_cell_index;
    logic [15:0]       max_cell_mv;
    logic [CELL_W-1:0] max_cell_index;
    logic signed [15:0] temperature;
  } out_item_t;

  typedef struct packed {
    logic                  wr;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

endpackage

[src/bmsfr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsfr channel interfaces
// Valid/ready channels for input beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface bmsfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface bmsfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] avg_cell_mv;
  logic [7:0]  error_bits;
  logic [15:0] balance_current;
  logic [7:0]  balance_active;
  logic [4:0]  cell_count;
  logic [20:0] cell_sum_mv;
  logic [15:0] min_cell_mv;
  logic [4:0]  min_cell_index;
  logic [15:0] max_cell_mv;
  logic [4:0]  max_cell_index;
  logic signed [15:0] temperature;

  modport source (output valid, output status, output avg_cell_mv, output error_bits,
                  output balance_current, output balance_active, output cell_count,
                  output cell_sum_mv, output min_cell_mv, output min_cell_index,
                  output max_cell_mv, output max_cell_index, output temperature,
                  input ready);
  modport sink   (input valid, input status, input avg_cell_mv, input error_bits,
                  input balance_current, input balance_active, input cell_count,
                  input cell_sum_mv, input min_cell_mv, input min_cell_index,
                  input max_cell_mv, input max_cell_index, input temperature,
                  output ready);
endinterface

interface bmsfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [15:0] wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

[src/bmsfr_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsfr_in_stage
// Input register: holds one accepted beat until the frame core takes it.
// ----------------------------------------------------------------------------
module bmsfr_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bmsfr_pkg::in_item_t  in_item,
  input  logic                 take,      // core consumes the held beat
  output logic                 hold_valid,
  output bmsfr_pkg::in_item_t  hold_item
);
  import bmsfr_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  // Free when empty or when the held beat leaves this cycle
  assign in_ready   = !valid_r || take;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

[src/bmsfr_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsfr_core
// Frame state: header search, checksum, payload field capture, cell stats,
// tick timeout and the configuration registers.
// ----------------------------------------------------------------------------
module bmsfr_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bmsfr_pkg::cfg_wr_t   cfg_wr,
  input  logic                 step,      // one beat processed this cycle
  input  bmsfr_pkg::in_item_t  item,
  output logic                 res_vld,
  output bmsfr_pkg::out_item_t res
);
  import bmsfr_pkg::*;

  typedef enum logic [2:0] {
    HDR_EB      = 3'd0,
    HDR_90      = 3'd1,
    HDR_ADDR    = 3'd2,
    HDR_FF      = 3'd3,
    HDR_PAYLOAD = 3'd4
  } hdr_t;

  // Configuration registers
  logic [15:0] timeout_r;
  logic [7:0]  slave_addr_r;

  // Receive state
  logic              armed_r,     armed_nxt;
  hdr_t              hdr_r,       hdr_nxt;
  logic [CNT_W-1:0]  cnt_r,       cnt_nxt;
  logic [7:0]        csum_r,      csum_nxt;
  logic [15:0]       tick_r,      tick_nxt;
  logic [7:0]        hi_r,        hi_nxt;
  logic [15:0]       avg_r,       avg_nxt;
  logic [7:0]        err_r,       err_nxt;
  logic [15:0]       bal_cur_r,   bal_cur_nxt;
  logic [7:0]        bal_act_r,   bal_act_nxt;
  logic [CELL_W-1:0] cells_r,     cells_nxt;
  logic [SUM_W-1:0]  cell_sum_r,  cell_sum_nxt;
  logic [15:0]       min_r,       min_nxt;
  logic [15:0]       max_r,       max_nxt;
  logic [CELL_W-1:0] min_idx_r,   min_idx_nxt;
  logic [CELL_W-1:0] max_idx_r,   max_idx_nxt;
  logic [15:0]       temp_r,      temp_nxt;

  logic [7:0]        b;
  logic [15:0]       word;
  logic [15:0]       tick_inc;
  logic              hdr_match;
  logic [CNT_W-1:0]  cell_off;
  logic [CNT_W-2:0]  cell_n;
  logic              cell_hit;
  logic [CELL_W-1:0] cell_idx;

  assign b        = item.rx_byte;
  assign word     = {hi_r, b};
  assign tick_inc = tick_r + 16'd1;
  assign cell_off = cnt_r - POS_CELL0_LO;
  assign cell_n   = cell_off[CNT_W-1:1];
  assign cell_idx = CELL_W'(cell_n + 1'b1);
  assign cell_hit = (cnt_r >= POS_CELL0_LO) && !cell_off[0] &&
                    (cell_n < (CNT_W-1)'(cells_r));

  // Header byte match for the current search position
  always_comb begin
    unique case (hdr_r)
      HDR_EB:   hdr_match = (b == HDR_BYTE0);
      HDR_90:   hdr_match = (b == HDR_BYTE1);
      HDR_ADDR: hdr_match = (b == slave_addr_r);
      HDR_FF:   hdr_match = (b == HDR_BYTE3);
      default:  hdr_match = 1'b0;
    endcase
  end

  // Next state and result for one beat
  always_comb begin
    armed_nxt    = armed_r;
    hdr_nxt      = hdr_r;
    cnt_nxt      = cnt_r;
    csum_nxt     = csum_r;
    tick_nxt     = tick_r;
    hi_nxt       = hi_r;
    avg_nxt      = avg_r;
    err_nxt      = err_r;
    bal_cur_nxt  = bal_cur_r;
    bal_act_nxt  = bal_act_r;
    cells_nxt    = cells_r;
    cell_sum_nxt = cell_sum_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    min_idx_nxt  = min_idx_r;
    max_idx_nxt  = max_idx_r;
    temp_nxt     = temp_r;
    res_vld      = 1'b0;
    res          = '0;

    if (step) begin
      case (func_t'(item.func))
        FUNC_ARM: begin
          armed_nxt    = 1'b1;
          hdr_nxt      = HDR_EB;
          cnt_nxt      = '0;
          csum_nxt     = '0;
          tick_nxt     = '0;
          hi_nxt       = '0;
          avg_nxt      = '0;
          err_nxt      = '0;
          bal_cur_nxt  = '0;
          bal_act_nxt  = '0;
          cells_nxt    = '0;
          cell_sum_nxt = '0;
          min_nxt      = 16'hFFFF;
          max_nxt      = '0;
          min_idx_nxt  = '0;
          max_idx_nxt  = '0;
          temp_nxt     = '0;
        end
        FUNC_TICK: begin
          if (armed_r) begin
            tick_nxt = tick_inc;
            if (tick_inc >= timeout_r) begin
              res_vld    = 1'b1;
              res.status = ST_TIMEOUT;
              armed_nxt  = 1'b0;
            end
          end
        end
        FUNC_BYTE: begin
          if (armed_r) begin
            if (hdr_r != HDR_PAYLOAD) begin
              // Header search: every byte counts in the checksum
              csum_nxt = csum_r + b;
              if (hdr_match) begin
                hdr_nxt = hdr_t'(hdr_r + 3'd1);
              end
            end else if (cnt_r == LAST_POS) begin
              // Checksum byte closes the frame
              res_vld   = 1'b1;
              armed_nxt = 1'b0;
              if (b == csum_r) begin
                res.status          = ST_OK;
                res.avg_cell_mv     = avg_r;
                res.error_bits      = err_r;
                res.balance_current = bal_cur_r;
                res.balance_active  = bal_act_r;
                res.cell_count      = cells_r;
                res.cell_sum_mv     = cell_sum_r;
                res.min_cell_mv     = min_r;
                res.min_cell_index  = min_idx_r;
                res.max_cell_mv     = max_r;
                res.max_cell_index  = max_idx_r;
                res.temperature     = temp_r;
              end else begin
                res.status = ST_CHKSUM;
              end
            end else begin
              csum_nxt = csum_r + b;
              cnt_nxt  = cnt_r + 1'b1;
              hi_nxt   = b;
              // Field capture by payload position
              case (cnt_r)
                POS_AVG_LO:  avg_nxt     = word;
                POS_ERR:     err_nxt     = b;
                POS_BAL_LO:  bal_cur_nxt = word;
                POS_BAL_ACT: bal_act_nxt = b;
                POS_CELLS:   cells_nxt   = (b > 8'(MAX_CELLS)) ? CELL_W'(MAX_CELLS)
                                                               : b[CELL_W-1:0];
                POS_TEMP_LO: temp_nxt    = word;
                default: ;
              endcase
              // Cell statistics on the low byte of each cell word
              if (cell_hit) begin
                cell_sum_nxt = cell_sum_r + SUM_W'(word);
                if (word <= min_r) begin
                  min_nxt     = word;
                  min_idx_nxt = cell_idx;
                end
                if (word >= max_r) begin
                  max_nxt     = word;
                  max_idx_nxt = cell_idx;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= TIMEOUT_RST;
      slave_addr_r <= '0;
    end else if (cfg_wr.wr) begin
      unique case (cfg_wr.addr)
        REG_TIMEOUT:    timeout_r    <= cfg_wr.wdata;
        REG_SLAVE_ADDR: slave_addr_r <= cfg_wr.wdata[7:0];
        default: ;
      endcase
    end
  end

  // Receive state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r    <= 1'b0;
      hdr_r      <= HDR_EB;
      cnt_r      <= '0;
      csum_r     <= '0;
      tick_r     <= '0;
      hi_r       <= '0;
      avg_r      <= '0;
      err_r      <= '0;
      bal_cur_r  <= '0;
      bal_act_r  <= '0;
      cells_r    <= '0;
      cell_sum_r <= '0;
      min_r      <= 16'hFFFF;
      max_r      <= '0;
      min_idx_r  <= '0;
      max_idx_r  <= '0;
      temp_r     <= '0;
    end else begin
      armed_r    <= armed_nxt;
      hdr_r      <= hdr_nxt;
      cnt_r      <= cnt_nxt;
      csum_r     <= csum_nxt;
      tick_r     <= tick_nxt;
      hi_r       <= hi_nxt;
      avg_r      <= avg_nxt;
      err_r      <= err_nxt;
      bal_cur_r  <= bal_cur_nxt;
      bal_act_r  <= bal_act_nxt;
      cells_r    <= cells_nxt;
      cell_sum_r <= cell_sum_nxt;
      min_r      <= min_nxt;
      max_r      <= max_nxt;
      min_idx_r  <= min_idx_nxt;
      max_idx_r  <= max_idx_nxt;
      temp_r     <= temp_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_POS)
    else $error("payload count past frame end");

  a_cnt_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (hdr_r == HDR_PAYLOAD))
    else $error("payload counted before header complete");

  a_res_armed: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> armed_r)
    else $error("result while not armed");

  a_disarm: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> !armed_r)
    else $error("receiver still armed after result");

  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (min_idx_r <= cells_r) && (max_idx_r <= cells_r))
    else $error("cell index beyond cell count");
`endif

endmodule

[src/bmsfr_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsfr_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module bmsfr_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_vld,
  input  bmsfr_pkg::out_item_t res,
  output logic                 free,      // register can take a result now
  output logic                 out_valid,
  input  logic                 out_ready,
  output bmsfr_pkg::out_item_t out_item
);
  import bmsfr_pkg::*;

  logic      valid_r;
  out_item_t item_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (free && res_vld) begin
      item_r <= res;
    end
  end

endmodule

[src/bms_frame_receiver_cell_stats_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_frame_receiver_cell_stats_unit
// Battery monitor answer receiver with per-frame cell statistics.
// ----------------------------------------------------------------------------
// The unit takes one beat per clock (received byte, time tick or arm) and
// sustains one beat per cycle while the result side keeps up. A beat is held
// in the input register, the frame core computes its next state and result
// from it combinationally, and a result (ok, checksum error or timeout, at
// most one per armed receive) is loaded into the result register once that
// register is free: the beat passes the input register and then the result
// register before out valid rises. The only stall source is a result beat
// held in the output register; the input register still takes one beat
// behind it.
// Configuration writes are taken every cycle and should be made while idle.
// ----------------------------------------------------------------------------
module bms_frame_receiver_cell_stats_unit (
  input  logic       clk,
  input  logic       rst_n,
  bmsfr_in_if.sink   in_ch,
  bmsfr_out_if.source out_ch,
  bmsfr_cfg_if.sink  cfg_ch
);
  import bmsfr_pkg::*;

  in_item_t  in_item;
  in_item_t  hold_item;
  logic      hold_valid;
  logic      out_free;
  logic      step;
  logic      res_vld;
  out_item_t res;
  out_item_t out_item;
  cfg_wr_t   cfg_wr;

  // Register writes always accepted
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr.wr    = cfg_ch.valid;
  assign cfg_wr.addr  = cfg_ch.addr;
  assign cfg_wr.wdata = cfg_ch.wdata;

  assign in_item.func    = in_ch.func;
  assign in_item.rx_byte = in_ch.rx_byte;

  // Core advances whenever a beat is held and the result register has room
  assign step = hold_valid && out_free;

  bmsfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .take       (out_free),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  bmsfr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_wr),
    .step    (step),
    .item    (hold_item),
    .res_vld (res_vld),
    .res     (res)
  );

  bmsfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .free      (out_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign out_ch.status          = out_item.status;
  assign out_ch.avg_cell_mv     = out_item.avg_cell_mv;
  assign out_ch.error_bits      = out_item.error_bits;
  assign out_ch.balance_current = out_item.balance_current;
  assign out_ch.balance_active  = out_item.balance_active;
  assign out_ch.cell_count      = out_item.cell_count;
  assign out_ch.cell_sum_mv     = out_item.cell_sum_mv;
  assign out_ch.min_cell_mv     = out_item.min_cell_mv;
  assign out_ch.min_cell_index  = out_item.min_cell_index;
  assign out_ch.max_cell_mv     = out_item.max_cell_mv;
  assign out_ch.max_cell_index  = out_item.max_cell_index;
  assign out_ch.temperature     = out_item.temperature;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the monitor frame receiver with cell statistics.
// Drives arm, tick and byte beats through the valid/ready input channel,
// models the receive state machine and the cell statistics in a scoreboard
// and compares every report beat field by field. Runs directed corner
// frames, then random frames, timeouts, truncated frames and noise under
// several idling profiles and register settings, and finishes with a long
// result stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
  import bmsfr_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int PAY_BYTES = FRAME_LEN - 1;

  // Receive model plus the queue of reports still owed by the block
  class cell_stats_scoreboard;
    typedef enum logic [2:0] {
      SEEK_SOF0, SEEK_SOF1, SEEK_ADDR, SEEK_EOH, IN_PAYLOAD
    } hdr_state_t;

    out_item_t pending_reports[$];
    int unsigned mismatches;
    int unsigned posted;

    logic [15:0] tmo_limit;
    logic [7:0]  dev_addr;

    bit                armed;
    hdr_state_t        hdr;
    logic [7:0]        pay_cnt;
    logic [7:0]        run_sum;
    logic [15:0]       ticks;
    logic [7:0]        hi_hold;
    logic [15:0]       avg_mv;
    logic [7:0]        err_byte;
    logic [15:0]       bal_ma;
    logic [7:0]        bal_flag;
    logic [CELL_W-1:0] ncells;
    logic [SUM_W-1:0]  total_mv;
    logic [15:0]       min_mv;
    logic [15:0]       max_mv;
    logic [CELL_W-1:0] min_idx;
    logic [CELL_W-1:0] max_idx;
    logic [15:0]       temp_word;

    function new();
      tmo_limit = TIMEOUT_RST;
      dev_addr = 8'h00;
      armed = 1'b0;
      mismatches = 0;
      posted = 0;
      clear_rx();
    endfunction

    function void clear_rx();
      hdr = SEEK_SOF0;
      pay_cnt = '0;
      run_sum = '0;
      ticks = '0;
      hi_hold = '0;
      avg_mv = '0;
      err_byte = '0;
      bal_ma = '0;
      bal_flag = '0;
      ncells = '0;
      total_mv = '0;
      min_mv = 16'hFFFF;
      max_mv = '0;
      min_idx = '0;
      max_idx = '0;
      temp_word = '0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_TIMEOUT) tmo_limit = val;
      else if (idx == REG_SLAVE_ADDR) dev_addr = val[7:0];
    endfunction

    // Queue one report; timeout and bad checksum carry status only
    function void post(logic [1:0] st, bit with_fields);
      out_item_t r;
      r = '0;
      r.status = st;
      if (with_fields) begin
        r.avg_cell_mv = avg_mv;
        r.error_bits = err_byte;
        r.balance_current = bal_ma;
        r.balance_active = bal_flag;
        r.cell_count = ncells;
        r.cell_sum_mv = total_mv;
        r.min_cell_mv = min_mv;
        r.min_cell_index = min_idx;
        r.max_cell_mv = max_mv;
        r.max_cell_index = max_idx;
        r.temperature = temp_word;
      end
      pending_reports.push_back(r);
      posted++;
      armed = 1'b0;
    endfunction

    function void note_beat(logic [1:0] f, logic [7:0] b);
      logic [15:0] word;
      logic [7:0]  pos;
      logic [7:0]  off;
      logic [7:0]  n;
      if (f == FUNC_ARM) begin
        clear_rx();
        armed = 1'b1;
        return;
      end
      if (!armed) return;
      if (f == FUNC_TICK) begin
        ticks = ticks + 16'd1;
        if (ticks >= tmo_limit) post(ST_TIMEOUT, 1'b0);
        return;
      end
      if (f != FUNC_BYTE) return;

      // Header search: every byte is summed, only a match advances
      if (hdr != IN_PAYLOAD) begin
        run_sum = run_sum + b;
        case (hdr)
          SEEK_SOF0: if (b == HDR_BYTE0) hdr = SEEK_SOF1;
          SEEK_SOF1: if (b == HDR_BYTE1) hdr = SEEK_ADDR;
          SEEK_ADDR: if (b == dev_addr) hdr = SEEK_EOH;
          SEEK_EOH:  if (b == HDR_BYTE3) hdr = IN_PAYLOAD;
          default: ;
        endcase
        return;
      end

      // Last byte of the frame is the checksum
      if (int'(pay_cnt) + 1 >= FRAME_LEN) begin
        if (b == run_sum) post(ST_OK, 1'b1);
        else post(ST_CHKSUM, 1'b0);
        return;
      end

      run_sum = run_sum + b;
      word = {hi_hold, b};
      pos = pay_cnt;
      case (pos)
        POS_AVG_LO:  avg_mv = word;
        POS_ERR:     err_byte = b;
        POS_BAL_LO:  bal_ma = word;
        POS_BAL_ACT: bal_flag = b;
        POS_CELLS:   ncells = (b > MAX_CELLS) ? CELL_W'(MAX_CELLS) : CELL_W'(b);
        POS_TEMP_LO: temp_word = word;
        default: ;
      endcase

      // Cell words end on even offsets from the first cell low byte
      if (pos >= POS_CELL0_LO) begin
        off = pos - POS_CELL0_LO;
        n = off >> 1;
        if (!off[0] && n < ncells) begin
          total_mv = total_mv + SUM_W'(word);
          if (word <= min_mv) begin
            min_mv = word;
            min_idx = CELL_W'(n + 8'd1);
          end
          if (word >= max_mv) begin
            max_mv = word;
            max_idx = CELL_W'(n + 8'd1);
          end
        end
      end
      hi_hold = b;
      pay_cnt = pay_cnt + 8'd1;
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      string bad;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: report beat with none pending: %p", $realtime, got);
        return;
      end
      want = pending_reports.pop_front();
      bad = "";
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.avg_cell_mv !== want.avg_cell_mv) bad = {bad, " avg_cell_mv"};
      if (got.error_bits !== want.error_bits) bad = {bad, " error_bits"};
      if (got.balance_current !== want.balance_current) bad = {bad, " balance_current"};
      if (got.balance_active !== want.balance_active) bad = {bad, " balance_active"};
      if (got.cell_count !== want.cell_count) bad = {bad, " cell_count"};
      if (got.cell_sum_mv !== want.cell_sum_mv) bad = {bad, " cell_sum_mv"};
      if (got.min_cell_mv !== want.min_cell_mv) bad = {bad, " min_cell_mv"};
      if (got.min_cell_index !== want.min_cell_index) bad = {bad, " min_cell_index"};
      if (got.max_cell_mv !== want.max_cell_mv) bad = {bad, " max_cell_mv"};
      if (got.max_cell_index !== want.max_cell_index) bad = {bad, " max_cell_index"};
      if (got.temperature !== want.temperature) bad = {bad, " temperature"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: report mismatch in%s", $realtime, bad);
          $display("  expected %p", want);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bmsfr_in_if  in_if ();
  bmsfr_out_if out_if ();
  bmsfr_cfg_if cfg_if ();

  bms_frame_receiver_cell_stats_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  cell_stats_scoreboard sb = new();

  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          items_sent = 0;
  logic [15:0] cur_tmo = TIMEOUT_RST;
  logic [7:0]  cur_addr = 8'h00;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: random stalls, or one long hold when asked
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // Beat monitor feeding the scoreboard
  always @(posedge clk) begin
    out_item_t got;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.status = out_if.status;
        got.avg_cell_mv = out_if.avg_cell_mv;
        got.error_bits = out_if.error_bits;
        got.balance_current = out_if.balance_current;
        got.balance_active = out_if.balance_active;
        got.cell_count = out_if.cell_count;
        got.cell_sum_mv = out_if.cell_sum_mv;
        got.min_cell_mv = out_if.min_cell_mv;
        got.min_cell_index = out_if.min_cell_index;
        got.max_cell_mv = out_if.max_cell_mv;
        got.max_cell_index = out_if.max_cell_index;
        got.temperature = out_if.temperature;
        sb.check_report(got);
      end
      if (in_if.valid && in_if.ready) sb.note_beat(in_if.func, in_if.rx_byte);
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.addr, cfg_if.wdata);
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    int quiet;
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $realtime, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic [7:0] pick_other(logic [7:0] avoid);
    logic [7:0] v;
    v = 8'($urandom);
    if (v == avoid) v = v + 8'd1;
    return v;
  endfunction

  // One input beat; valid drops only for an idle gap drawn before it
  task automatic send_beat(input logic [1:0] f, input logic [7:0] b);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_if.valid <= 1'b1;
    in_if.func <= f;
    in_if.rx_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.addr <= idx;
    cfg_if.wdata <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every report is in and the pipeline has settled
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] tmo, input logic [7:0] addr);
    drain();
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_SLAVE_ADDR, {8'h00, addr});
    cur_tmo = tmo;
    cur_addr = addr;
  endtask

  // Arm, header with optional stray bytes, payload with ticks mixed in,
  // then the checksum; trunc >= 0 stops after that many payload bytes
  task automatic send_frame(input int cnt_byte, input int mode, input logic [15:0] fixed,
                            input bit bad_sum, input int noise_pct, input int n_ticks,
                            input int trunc);
    logic [7:0]  pl [PAY_BYTES];
    logic [7:0]  hdr [4];
    logic [7:0]  cks;
    logic [7:0]  g;
    logic [15:0] w;
    int          ticks_left;
    int          n_pay;
    cks = '0;
    ticks_left = n_ticks;
    for (int i = 0; i < PAY_BYTES; i++) pl[i] = 8'($urandom);
    for (int n = 0; n < MAX_CELLS; n++) begin
      case (mode)
        0: w = 16'($urandom);
        1: w = fixed;
        2: w = n[0] ? 16'hFFFF : 16'h0000;
        default: w = fixed + 16'($urandom_range(2));
      endcase
      pl[POS_CELL0_LO - 1 + 2 * n] = w[15:8];
      pl[POS_CELL0_LO + 2 * n] = w[7:0];
    end
    pl[POS_CELLS] = 8'(cnt_byte);
    hdr[0] = HDR_BYTE0;
    hdr[1] = HDR_BYTE1;
    hdr[2] = cur_addr;
    hdr[3] = HDR_BYTE3;

    send_beat(FUNC_ARM, 8'($urandom));
    repeat ($urandom_range(2)) begin
      g = pick_other(HDR_BYTE0);
      send_beat(FUNC_BYTE, g);
      cks = cks + g;
    end
    for (int h = 0; h < 4; h++) begin
      if ($urandom_range(99) < noise_pct) begin
        g = pick_other(hdr[h]);
        send_beat(FUNC_BYTE, g);
        cks = cks + g;
      end
      send_beat(FUNC_BYTE, hdr[h]);
      cks = cks + hdr[h];
    end

    n_pay = (trunc < 0) ? PAY_BYTES : trunc;
    for (int i = 0; i < n_pay; i++) begin
      if (ticks_left > 0 && $urandom_range(9) == 0) begin
        send_beat(FUNC_TICK, 8'($urandom));
        ticks_left--;
      end
      send_beat(FUNC_BYTE, pl[i]);
      cks = cks + pl[i];
    end
    if (trunc < 0) begin
      while (ticks_left > 0) begin
        send_beat(FUNC_TICK, 8'($urandom));
        ticks_left--;
      end
      if (bad_sum) cks = cks ^ 8'($urandom_range(1, 255));
      send_beat(FUNC_BYTE, cks);
    end
  endtask

  // Mostly whole frames, plus timeouts, cut-off frames and loose beats
  task automatic run_random(input int n_items, input int n_reports);
    int          start_items;
    int          start_reports;
    int          r;
    int          nt;
    int          lim;
    int          cnt;
    logic [15:0] fw;
    start_items = items_sent;
    start_reports = sb.posted;
    while (items_sent - start_items < n_items || sb.posted - start_reports < n_reports) begin
      r = $urandom_range(99);
      case ($urandom_range(9))
        0: cnt = 0;
        1: cnt = MAX_CELLS;
        2: cnt = $urandom_range(MAX_CELLS + 1, 255);
        3: cnt = 1;
        default: cnt = $urandom_range(1, MAX_CELLS);
      endcase
      case ($urandom_range(3))
        0: fw = 16'h0000;
        1: fw = 16'hFFFF;
        default: fw = 16'($urandom);
      endcase
      if (r < 60) begin
        if (cur_tmo <= 200 && $urandom_range(7) == 0) begin
          nt = cur_tmo;
        end else begin
          lim = (cur_tmo > 4) ? 3 : ((cur_tmo > 0) ? int'(cur_tmo) - 1 : 0);
          nt = $urandom_range(lim);
        end
        send_frame(cnt, $urandom_range(3), fw, ($urandom_range(9) == 0),
                   ($urandom_range(1) == 1) ? 25 : 0, nt, -1);
      end else if (r < 75) begin
        send_beat(FUNC_ARM, 8'($urandom));
        nt = (cur_tmo <= 300) ? int'(cur_tmo) : $urandom_range(1, 10);
        if (nt > 1 && $urandom_range(3) == 0) nt = nt - 1;
        repeat (nt) send_beat(FUNC_TICK, 8'($urandom));
      end else if (r < 88) begin
        send_frame(cnt, 0, fw, 1'b0, 25, 0, $urandom_range(PAY_BYTES - 1));
      end else begin
        repeat ($urandom_range(1, 8)) send_beat(2'($urandom_range(3)), 8'($urandom));
      end
    end
  endtask

  // Main sequence
  initial begin
    in_if.valid <= 1'b0;
    in_if.func <= FUNC_BYTE;
    in_if.rx_byte <= 8'h00;
    cfg_if.valid <= 1'b0;
    cfg_if.addr <= REG_TIMEOUT;
    cfg_if.wdata <= '0;
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset register values first
    send_beat(FUNC_BYTE, 8'h00);
    send_beat(FUNC_TICK, 8'hFF);
    send_beat(FUNC_UNUSED, 8'hFF);
    send_beat(FUNC_BYTE, 8'hFF);
    send_beat(FUNC_ARM, 8'h00);
    send_beat(FUNC_TICK, 8'h00);
    send_beat(FUNC_UNUSED, 8'h55);
    send_beat(FUNC_BYTE, HDR_BYTE0);
    // re-arm mid header; full cell set all at max, ties go to the last cell
    send_frame(MAX_CELLS, 1, 16'hFFFF, 1'b0, 100, 2, -1);
    send_frame(0, 0, 16'h0000, 1'b1, 0, 0, -1);
    send_frame(1, 1, 16'h0000, 1'b0, 0, 0, -1);
    // zero timeout: first tick ends the receive
    set_config(16'd0, 8'hFF);
    send_beat(FUNC_ARM, 8'hFF);
    send_beat(FUNC_TICK, 8'h00);
    send_beat(FUNC_TICK, 8'h00);
    send_frame(255, 2, 16'h0000, 1'b0, 50, 0, -1);

    // Random phases over idling profiles and register settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 0;
          set_config(16'hFFFF, HDR_BYTE0);
        end
        1: begin
          snd_idle_pct = 82;
          rcv_stall_pct = 0;
          set_config(16'($urandom_range(20, 120)), HDR_BYTE1);
        end
        2: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 82;
          set_config(16'd3, 8'($urandom));
        end
        default: begin
          snd_idle_pct = 29;
          rcv_stall_pct = 29;
          set_config(16'($urandom_range(1, 65535)), 8'($urandom));
        end
      endcase
      run_random(350, 10);
    end

    // Long result hold while arm/tick pairs keep coming
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    set_config(16'd1, 8'($urandom));
    hold_req = 1'b1;
    repeat (30) begin
      send_beat(FUNC_ARM, 8'($urandom));
      send_beat(FUNC_TICK, 8'($urandom));
    end

    drain();
    if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
src/bmsfr_pkg.sv
src/bmsfr_if.sv
src/bmsfr_in_stage.sv
src/bmsfr_core.sv
src/bmsfr_out_stage.sv
src/bms_frame_receiver_cell_stats_unit.sv
verif/tb_top.sv
